// ===== design/rational_arithmetic_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the rational arithmetic unit.
// ---------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RAU_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define RAU_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);
`endif

// ===== design/rau_pkg.sv =====
// ---------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared opcodes, widths and controller command/status types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package rau_pkg;
  localparam int OperandWidthDefault = 32;
  localparam int RW = 64;
  localparam int IW = 32;

  localparam logic [2:0] OP_NORM = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_CMP  = 3'd5;

  localparam logic [1:0] ORD_EQ   = 2'd0;
  localparam logic [1:0] ORD_LESS = 2'd1;
  localparam logic [1:0] ORD_GT   = 2'd2;

  // Datapath commands.
  localparam logic [3:0] CMD_NONE   = 4'd0;
  localparam logic [3:0] CMD_LOAD   = 4'd1;  // capture request, load A into reducer
  localparam logic [3:0] CMD_GCD    = 4'd2;  // one Euclid remainder step
  localparam logic [3:0] CMD_GDIV   = 4'd3;  // start dividing num/den by gcd
  localparam logic [3:0] CMD_QSTEP  = 4'd4;  // one quotient bit
  localparam logic [3:0] CMD_SAVEA  = 4'd5;  // store reduced A, load B
  localparam logic [3:0] CMD_SAVEB  = 4'd6;  // store reduced B
  localparam logic [3:0] CMD_MUL1   = 4'd7;  // first cross products
  localparam logic [3:0] CMD_MUL2   = 4'd8;  // combine, load into reducer
  localparam logic [3:0] CMD_RESULT = 4'd9;  // publish reduced result
  localparam logic [3:0] CMD_CMPRES = 4'd10;
  localparam logic [3:0] CMD_ERROR  = 4'd11;
  localparam logic [3:0] CMD_SETUP  = 4'd12; // prepare one remainder division

  typedef struct packed {
    logic [3:0] cmd;
  } ctrl_t;

  typedef struct packed {
    logic [2:0] op;
    logic       den_zero;   // reducer denominator is zero
    logic       y_zero;     // Euclid divisor is zero
    logic       div_done;   // bit-serial division finished
    logic       b_num_zero;
  } stat_t;
endpackage

// ===== design/rau_datapath.sv =====
// ---------------------------------------------------------------------------
// Rational arithmetic datapath
// Reducer with a shared bit-serial divider, cross multipliers and result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module rau_datapath #(
  parameter int OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
  input  logic                clk,
  input  rau_pkg::ctrl_t      ctrl,
  output rau_pkg::stat_t      stat,
  input  logic [2:0]          in_op,
  input  logic [31:0]         in_a_num,
  input  logic [31:0]         in_a_den,
  input  logic [31:0]         in_b_num,
  input  logic [31:0]         in_b_den,
  output logic [63:0]         res_num,
  output logic [62:0]         res_den,
  output logic [1:0]          order,
  output logic                status
);
  localparam int W = rau_pkg::RW;
  localparam int CW = $clog2(W + 1);

  logic [2:0] op;
  logic signed [63:0] bn_raw, bd_raw;
  logic signed [63:0] an, ad, bn, bd;
  logic               neg;
  logic [63:0]        mn, md, x, y;
  logic [63:0]        dvd, dvs, quo, rem;
  logic [1:0]         phase;
  logic [CW-1:0]      cnt;
  logic signed [63:0] p0, p1, p2, p3;

  function automatic logic signed [63:0] sx(input logic [31:0] v);
    logic [OPERAND_WIDTH-1:0] t;
    t = v[OPERAND_WIDTH-1:0];
    return 64'(signed'(t));
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Reduced operands fit in 32 signed bits unless a reduced magnitude is 2^31.
  function automatic logic signed [63:0] mul32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return a * b;
  endfunction

  logic [63:0] rem_sh;
  logic        sub_ok;
  assign rem_sh = {rem[62:0], dvd[63]};
  assign sub_ok = rem[63] || (rem_sh >= dvs);

  logic signed [63:0] comb_num, comb_den;
  always_comb begin
    comb_num = p0;
    comb_den = p2;
    case (op)
      rau_pkg::OP_ADD: comb_num = p0 + p1;
      rau_pkg::OP_SUB: comb_num = p0 - p1;
      rau_pkg::OP_MUL: comb_num = p3;
      rau_pkg::OP_DIV: begin
        comb_num = p0;
        comb_den = p1;
      end
      default: comb_num = p0;
    endcase
  end

  task automatic load_red(input logic signed [63:0] n, input logic signed [63:0] d);
    neg <= (n < 0) != (d < 0);
    mn  <= mag(n);
    md  <= mag(d);
    x   <= mag(n);
    y   <= mag(d);
  endtask

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      rau_pkg::CMD_LOAD: begin
        op     <= in_op;
        bn_raw <= sx(in_b_num);
        bd_raw <= sx(in_b_den);
        load_red(sx(in_a_num), sx(in_a_den));
      end
      rau_pkg::CMD_SETUP: begin
        dvd <= x;
        dvs <= y;
        rem <= '0;
        cnt <= '0;
        phase <= 2'd0;
      end
      rau_pkg::CMD_QSTEP: begin
        rem <= sub_ok ? rem_sh - dvs : rem_sh;
        dvd <= {dvd[62:0], sub_ok};
        cnt <= cnt + CW'(1);
      end
      rau_pkg::CMD_GCD: begin
        x <= y;
        y <= rem;
      end
      rau_pkg::CMD_GDIV: begin
        if (phase == 2'd0) begin
          dvd <= mn; dvs <= x; rem <= '0; cnt <= '0; phase <= 2'd1;
        end else begin
          quo <= dvd;
          dvd <= md; dvs <= x; rem <= '0; cnt <= '0; phase <= 2'd2;
        end
      end
      rau_pkg::CMD_SAVEA: begin
        an <= neg ? 64'(-quo) : quo;
        ad <= dvd;
        load_red(bn_raw, bd_raw);
      end
      rau_pkg::CMD_SAVEB: begin
        bn <= neg ? 64'(-quo) : quo;
        bd <= dvd;
      end
      rau_pkg::CMD_MUL1: begin
        p0 <= mul32(an[31:0], bd[31:0]);
        p1 <= mul32(ad[31:0], bn[31:0]);
        p2 <= mul32(ad[31:0], bd[31:0]);
        p3 <= mul32(an[31:0], bn[31:0]);
      end
      rau_pkg::CMD_MUL2: load_red(comb_num, comb_den);
      rau_pkg::CMD_RESULT: begin
        res_num <= neg ? 64'(-quo) : quo;
        res_den <= dvd[62:0];
        order   <= rau_pkg::ORD_EQ;
        status  <= 1'b0;
      end
      rau_pkg::CMD_CMPRES: begin
        res_num <= '0;
        res_den <= 63'd1;
        order   <= (p0 == p1) ? rau_pkg::ORD_EQ :
                   ((p0 < p1) ? rau_pkg::ORD_LESS : rau_pkg::ORD_GT);
        status  <= 1'b0;
      end
      rau_pkg::CMD_ERROR: begin
        res_num <= '0;
        res_den <= '0;
        order   <= rau_pkg::ORD_EQ;
        status  <= 1'b1;
      end
      default: ;
    endcase
  end

  assign stat.op         = op;
  assign stat.den_zero   = (md == '0);
  assign stat.y_zero     = (y == '0);
  assign stat.div_done   = (cnt == CW'(W));
  assign stat.b_num_zero = (bn == '0);
endmodule

// ===== design/rau_control.sv =====
// ---------------------------------------------------------------------------
// Rational arithmetic controller
// Sequences reductions, divisions, products and the result handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module rau_control (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output rau_pkg::ctrl_t ctrl,
  input  rau_pkg::stat_t stat
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_GTST = 4'd2;
  localparam logic [3:0] S_GSTP = 4'd4;
  localparam logic [3:0] S_QST1 = 4'd6;
  localparam logic [3:0] S_QST2 = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;
  localparam logic [3:0] S_MUL1 = 4'd9;
  localparam logic [3:0] S_MUL2 = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0] state, state_next;
  logic [1:0] pass, pass_next;  // 0 reducing A, 1 reducing B, 2 result
  logic       out_valid_next;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    state_next     = state;
    pass_next      = pass;
    out_valid_next = out_valid && !out_ready;
    ctrl.cmd       = rau_pkg::CMD_NONE;
    case (state)
      S_IDLE: if (in_fire) begin
        ctrl.cmd   = rau_pkg::CMD_LOAD;
        pass_next  = 2'd0;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (pass == 2'd0 && stat.op > rau_pkg::OP_CMP) begin
          ctrl.cmd = rau_pkg::CMD_ERROR;
          state_next = S_OUT;
        end else if (stat.den_zero) begin
          ctrl.cmd = rau_pkg::CMD_ERROR;
          state_next = S_OUT;
        end else state_next = S_GTST;
      end
      S_GTST: begin
        if (stat.y_zero) begin
          ctrl.cmd = rau_pkg::CMD_GDIV;
          state_next = S_QST1;
        end else begin
          ctrl.cmd = rau_pkg::CMD_SETUP;
          state_next = S_GSTP;
        end
      end
      S_GSTP: begin
        ctrl.cmd = rau_pkg::CMD_QSTEP;
        if (stat.div_done) begin
          ctrl.cmd = rau_pkg::CMD_GCD;
          state_next = S_GTST;
        end
      end
      S_QST1: begin
        ctrl.cmd = rau_pkg::CMD_QSTEP;
        if (stat.div_done) begin
          ctrl.cmd = rau_pkg::CMD_GDIV;
          state_next = S_QST2;
        end
      end
      S_QST2: begin
        ctrl.cmd = rau_pkg::CMD_QSTEP;
        if (stat.div_done) begin
          ctrl.cmd = rau_pkg::CMD_NONE;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (pass == 2'd0) begin
          ctrl.cmd = rau_pkg::CMD_SAVEA;
          if (stat.op == rau_pkg::OP_NORM) begin
            ctrl.cmd = rau_pkg::CMD_RESULT;
            state_next = S_OUT;
          end else begin
            pass_next = 2'd1;
            state_next = S_CHK;
          end
        end else if (pass == 2'd1) begin
          ctrl.cmd = rau_pkg::CMD_SAVEB;
          state_next = S_MUL1;
        end else begin
          ctrl.cmd = rau_pkg::CMD_RESULT;
          state_next = S_OUT;
        end
      end
      S_MUL1: begin
        ctrl.cmd = rau_pkg::CMD_MUL1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        if (stat.op == rau_pkg::OP_CMP) begin
          ctrl.cmd = rau_pkg::CMD_CMPRES;
          state_next = S_OUT;
        end else if (stat.op == rau_pkg::OP_DIV && stat.b_num_zero) begin
          ctrl.cmd = rau_pkg::CMD_ERROR;
          state_next = S_OUT;
        end else begin
          ctrl.cmd = rau_pkg::CMD_MUL2;
          pass_next = 2'd2;
          state_next = S_CHK;
        end
      end
      S_OUT: begin
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pass      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pass      <= pass_next;
      out_valid <= out_valid_next;
    end
  end
endmodule

// ===== design/rational_arithmetic_unit.sv =====
// Work per request is set by the bit-serial divider, run once per Euclid step and
// twice per reduction.
// Up to three reductions per request.
// A new request is taken once the previous result has been delivered.
// Synchronous active-high reset clears the controller and output valid.
// ---------------------------------------------------------------------------
// Rational arithmetic unit
// Fraction arithmetic with gcd reduction on a streaming interface.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,  // op[2:0], a_num, a_den, b_num, b_den, zero pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata   // res_num, res_den, order, status, zero pad
);
  rau_pkg::ctrl_t ctrl;
  rau_pkg::stat_t stat;
  logic [63:0] res_num;
  logic [62:0] res_den;
  logic [1:0]  order;
  logic        status;

  rau_control u_ctrl (
    .clk(clk), .rst(rst), .in_fire(s_tvalid && s_tready), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready), .ctrl(ctrl), .stat(stat)
  );

  rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk(clk), .ctrl(ctrl), .stat(stat),
    .in_op(s_tdata[2:0]), .in_a_num(s_tdata[34:3]), .in_a_den(s_tdata[66:35]),
    .in_b_num(s_tdata[98:67]), .in_b_den(s_tdata[130:99]),
    .res_num(res_num), .res_den(res_den), .order(order), .status(status)
  );

  assign m_tdata = {6'd0, status, order, res_den, res_num};
endmodule

// ===== design/rau_checker.sv =====
// ---------------------------------------------------------------------------
// Rational arithmetic unit checker
// Port-level properties of the request and result channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_assert.svh"
module rau_props (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [135:0] m_tdata
);
  `RAU_ASSERT_IMP(no_take_while_busy, clk, rst, m_tvalid, !s_tready, "request taken with result pending")
  `RAU_ASSERT_NEXT(no_result_after_take, clk, rst, s_tvalid && s_tready, !m_tvalid, "result too early")
  `RAU_ASSERT_IMP(err_fields, clk, rst, m_tvalid && m_tdata[129], m_tdata[126:64] == 63'd0 && m_tdata[63:0] == 64'd0, "error result not cleared")
  `RAU_ASSERT_NEXT(hold_result, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
endmodule

bind rational_arithmetic_unit rau_props u_rau_props (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== bench/rau_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Rational arithmetic unit checker
// Watches both stream channels and predicts each reduced fraction or compare
// outcome. Every delivered response is compared field by field with the
// oldest prediction.
// ---------------------------------------------------------------------------
module rau_checker
  import rau_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [135:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [135:0] m_tdata,
  output int           fail_count,
  output int           pending
);
  typedef struct packed {
    logic signed [63:0] num;
    logic [62:0]        den;
    logic [1:0]         ord;
    logic               status;
  } frac_result_t;

  frac_result_t expected_fracs[$];

  function automatic bit reduce_frac(input longint n, input longint d,
                                     output longint rn, output longint rd);
    longint unsigned mn, md, x, y, t;
    bit neg;
    if (d == 0) return 0;
    neg = (n < 0) != (d < 0);
    mn = n < 0 ? -n : n;
    md = d < 0 ? -d : d;
    x = mn;
    y = md;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    mn = mn / x;
    md = md / x;
    rn = neg ? -longint'(mn) : longint'(mn);
    rd = longint'(md);
    return 1;
  endfunction

  function automatic frac_result_t compute_fraction(input logic [135:0] req);
    frac_result_t r;
    logic [2:0] op;
    longint an, ad, bn, bd, rn, rd, l, rr;
    bit ok;
    op = req[2:0];
    r = '{num: 0, den: 0, ord: ORD_EQ, status: 1'b1};
    if (op > OP_CMP) return r;
    if (!reduce_frac(longint'($signed(req[34:3])), longint'($signed(req[66:35])), an, ad))
      return r;
    if (op == OP_NORM) begin
      rn = an;
      rd = ad;
    end else begin
      if (!reduce_frac(longint'($signed(req[98:67])), longint'($signed(req[130:99])),
                       bn, bd))
        return r;
      case (op)
        OP_ADD: ok = reduce_frac(an * bd + ad * bn, ad * bd, rn, rd);
        OP_SUB: ok = reduce_frac(an * bd - ad * bn, ad * bd, rn, rd);
        OP_MUL: ok = reduce_frac(an * bn, ad * bd, rn, rd);
        OP_DIV: ok = reduce_frac(an * bd, ad * bn, rn, rd);
        default: begin
          l = an * bd;
          rr = ad * bn;
          r.ord = (l == rr) ? ORD_EQ : (l < rr ? ORD_LESS : ORD_GT);
          rn = 0;
          rd = 1;
          ok = 1;
        end
      endcase
      if (!ok) begin
        r.ord = ORD_EQ;
        return r;
      end
    end
    r.num = rn;
    r.den = rd[62:0];
    r.status = 1'b0;
    return r;
  endfunction

  assign pending = expected_fracs.size();

  always @(posedge clk) begin
    frac_result_t e;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (s_tvalid && s_tready) expected_fracs.push_back(compute_fraction(s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_fracs.size() == 0) begin
          $error("Response with no request outstanding: %h", m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_fracs.pop_front();
          if (m_tdata[63:0] !== e.num || m_tdata[126:64] !== e.den ||
              m_tdata[128:127] !== e.ord || m_tdata[129] !== e.status) begin
            if (m_tdata[63:0] !== e.num)
              $error("res_num: expected %0d, actual %0d", e.num, $signed(m_tdata[63:0]));
            if (m_tdata[126:64] !== e.den)
              $error("res_den: expected %0d, actual %0d", e.den, m_tdata[126:64]);
            if (m_tdata[128:127] !== e.ord)
              $error("order: expected %0d, actual %0d", e.ord, m_tdata[128:127]);
            if (m_tdata[129] !== e.status)
              $error("status: expected %0d, actual %0d", e.status, m_tdata[129]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== bench/tb_rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Sends directed and random fraction requests under varying stalls on both
// channels; the checker predicts and compares every response.
// ---------------------------------------------------------------------------
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  localparam longint CycleLimit = 64'd60_000_000;
  localparam int RandomRequests = 830;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;
  int           fail_count;
  int           pending;
  int           send_idle_pct = 23;
  int           recv_idle_pct = 52;
  longint       cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rational_arithmetic_unit i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  rau_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic send_request(input logic [2:0] op, input logic [31:0] an,
                              input logic [31:0] ad, input logic [31:0] bn,
                              input logic [31:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {5'b0, bd, bn, ad, an, op};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    logic [31:0] v;
    case ($urandom_range(9))
      0: v = 0;
      1, 2, 3: begin
        v = $urandom;
        if (v == 32'h8000_0000) v = 32'h8000_0001;
      end
      4, 5: v = $urandom_range(5000) - 2500;
      default: v = $urandom_range(60) - 30;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_den();
    logic [31:0] v;
    v = rand_operand();
    if (v == 0 && $urandom_range(15) != 0) v = 1;
    return v;
  endfunction

  initial begin
    logic [2:0] op;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_request(OP_NORM, 32'h7fff_ffff, 32'h8000_0001, 0, 0);
    send_request(OP_NORM, 0, -32'sd7, 3, 4);
    send_request(OP_NORM, 12, 0, 1, 1);
    send_request(OP_NORM, -32'sd18, -32'sd12, 1, 1);
    send_request(OP_ADD, 32'h7fff_ffff, 32'h7fff_fffe, 32'h8000_0001, 32'h7fff_fffd);
    send_request(OP_ADD, 1, 2, 1, 3);
    send_request(OP_ADD, 1, 2, 1, 0);
    send_request(OP_SUB, 32'h8000_0001, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0001);
    send_request(OP_SUB, 3, 4, 3, 4);
    send_request(OP_MUL, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
    send_request(OP_MUL, 0, 5, 7, 9);
    send_request(OP_DIV, 2, 3, 0, 5);
    send_request(OP_DIV, 32'h8000_0001, 3, 5, 32'h7fff_ffff);
    send_request(OP_CMP, 1, 2, 2, 4);
    send_request(OP_CMP, -32'sd1, 2, 1, 3);
    send_request(OP_CMP, 5, 3, 32'h8000_0001, 1);
    send_request(OP_CMP, 1, 0, 1, 1);
    send_request(3'd6, 1, 1, 1, 1);
    send_request(3'd7, 2, 3, 4, 5);

    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);

    for (int i = 0; i < RandomRequests; i++) begin
      if (i == RandomRequests / 3) begin
        send_idle_pct = 52;
        recv_idle_pct = 23;
      end else if (i == 2 * RandomRequests / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      op = ($urandom_range(39) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      send_request(op, rand_operand(), rand_den(), rand_operand(), rand_den());
    end
    s_tvalid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (2000) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/rau_pkg.sv
design/rau_datapath.sv
design/rau_control.sv
design/rational_arithmetic_unit.sv
design/rau_checker.sv
bench/rau_checker.sv
bench/tb_rational_arithmetic_unit.sv
